// ===== sv/gbt_pkg.sv =====
// ----------------------------------------------------------------------------
// gbt_pkg
// shared sizes, codes and types of the graph traversal unit
// ----------------------------------------------------------------------------
package gbt_pkg;

   localparam int NODES       = 16;
   localparam int MAX_DEGREE  = 8;
   localparam int MAX_RESULTS = 16;
   localparam int NODE_W      = 4;
   localparam int SLOTS       = NODES * MAX_DEGREE;
   localparam int WORK_DEPTH  = SLOTS + 1;
   localparam int ADJ_AW      = $clog2(SLOTS);
   localparam int WORK_AW     = $clog2(WORK_DEPTH);
   localparam int CNT_W       = $clog2(WORK_DEPTH + 1);
   localparam int DEG_W       = $clog2(MAX_DEGREE + 1);
   localparam int NVIS_W      = $clog2(MAX_RESULTS + 1);
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 8;

   typedef enum logic [1:0] {
      REQ_ADD_EDGE = 2'd0,
      REQ_BFS      = 2'd1,
      REQ_DFS      = 2'd2,
      REQ_CLEAR    = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      STAT_VISITED  = 2'd0,
      STAT_STORED   = 2'd1,
      STAT_REJECTED = 2'd2,
      STAT_CLEARED  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD_A,
      S_ADD_B,
      S_ADD_W2,
      S_RESULT,
      S_INIT,
      S_POP,
      S_POP_WAIT,
      S_VISIT,
      S_SCAN,
      S_FLUSH
   } state_type;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      status_type        status;
      logic              last;
   } rsp_item_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADJ_AW-1:0] wr_addr;
      logic [NODE_W-1:0] wr_data;
      logic              rd_en;
      logic [ADJ_AW-1:0] rd_addr;
   } adj_port_type;

   typedef struct packed {
      logic               wr_en;
      logic [WORK_AW-1:0] wr_addr;
      logic [NODE_W-1:0]  wr_data;
      logic               rd_en;
      logic [WORK_AW-1:0] rd_addr;
   } work_port_type;

   function automatic logic [ADJ_AW-1:0] adj_addr(input logic [NODE_W-1:0] node,
                                                  input logic [DEG_W-1:0]  slot);
      logic [ADJ_AW-1:0] base;
      base = ADJ_AW'(node) * ADJ_AW'(MAX_DEGREE);
      return base + ADJ_AW'(slot);
   endfunction

endpackage

// ===== sv/gbt_ram.sv =====
// ----------------------------------------------------------------------------
// gbt_ram
// simple dual port synchronous ram, one write and one registered read
// ----------------------------------------------------------------------------
module gbt_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/gbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbt_ctrl
// sequencer for edge insertion, graph clear and breadth/depth-first walks
// ----------------------------------------------------------------------------
module gbt_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  gbt_pkg::req_kind_type       req_kind,
   input  logic [gbt_pkg::NODE_W-1:0]  node_a,
   input  logic [gbt_pkg::NODE_W-1:0]  node_b,
   input  logic [gbt_pkg::NODE_W-1:0]  start_node,
   output logic                        emit_valid,
   input  logic                        emit_ready,
   output gbt_pkg::rsp_item_type       emit_item,
   output gbt_pkg::adj_port_type       adj_port,
   input  logic [gbt_pkg::NODE_W-1:0]  adj_rd_data,
   output gbt_pkg::work_port_type      work_port,
   input  logic [gbt_pkg::NODE_W-1:0]  work_rd_data
);

   import gbt_pkg::*;

   state_type         state_ff, state_in;
   logic              mode_dfs_ff, mode_dfs_in;
   logic [NODE_W-1:0] a_ff, a_in;
   logic [NODE_W-1:0] b_ff, b_in;
   logic [NODE_W-1:0] cur_ff, cur_in;
   logic [DEG_W-1:0]  deg_ff [NODES];
   logic [DEG_W-1:0]  deg_a_ff, deg_a_in;
   status_type        status_ff, status_in;
   logic [NODES-1:0]  visited_ff, visited_in;
   logic [CNT_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DEG_W-1:0]  idx_ff, idx_in;
   logic              nb_pend_ff, nb_pend_in;
   logic [NVIS_W-1:0] nvis_ff, nvis_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [NODE_W-1:0] pend_node_ff, pend_node_in;

   logic              deg_we;
   logic              deg_clr;
   logic [NODE_W-1:0] deg_wr_idx;
   logic [DEG_W-1:0]  deg_wr_val;
   logic [NODE_W-1:0] deg_rd_idx;
   logic [DEG_W-1:0]  deg_rd;
   logic [NODE_W-1:0] vis_idx;
   logic              vis_rd;
   logic              add_ok;
   logic              pop_ok;
   logic              scan_more;
   logic              out_free;
   logic [CNT_W-1:0]  cnt_dec;
   logic              accept;

   // single read port on the degree and visited registers
   always_comb begin
      case (state_ff)
         S_ADD_A:  deg_rd_idx = a_ff;
         S_ADD_B:  deg_rd_idx = b_ff;
         S_ADD_W2: deg_rd_idx = b_ff;
         default:  deg_rd_idx = cur_ff;
      endcase
   end

   assign deg_rd  = deg_ff[deg_rd_idx];
   assign vis_idx = (state_ff == S_POP_WAIT) ? work_rd_data : adj_rd_data;
   assign vis_rd  = visited_ff[vis_idx];

   assign add_ok = (a_ff == b_ff) ?
                   (({1'b0, deg_a_ff} + (DEG_W+1)'(2)) <= (DEG_W+1)'(MAX_DEGREE)) :
                   ((deg_a_ff < DEG_W'(MAX_DEGREE)) && (deg_rd < DEG_W'(MAX_DEGREE)));
   assign pop_ok = (mode_dfs_ff ? (count_ff != '0) : (head_ff < count_ff)) &&
                   (nvis_ff < NVIS_W'(MAX_RESULTS));
   assign scan_more = idx_ff < deg_rd;
   assign out_free  = !pend_valid_ff || emit_ready;
   assign cnt_dec   = count_ff - CNT_W'(1);
   assign accept    = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  REQ_ADD_EDGE: state_in = S_ADD_A;
                  REQ_CLEAR:    state_in = S_RESULT;
                  default:      state_in = S_INIT;
               endcase
            end
         end
         S_ADD_A:    state_in = S_ADD_B;
         S_ADD_B:    state_in = add_ok ? S_ADD_W2 : S_RESULT;
         S_ADD_W2:   state_in = S_RESULT;
         S_RESULT:   state_in = emit_ready ? S_IDLE : S_RESULT;
         S_INIT:     state_in = S_POP;
         S_POP:      state_in = pop_ok ? S_POP_WAIT : S_FLUSH;
         S_POP_WAIT: state_in = (mode_dfs_ff && vis_rd) ? S_POP : S_VISIT;
         S_VISIT:    state_in = out_free ? S_SCAN : S_VISIT;
         S_SCAN:     state_in = scan_more ? S_SCAN : S_POP;
         S_FLUSH:    state_in = out_free ? S_IDLE : S_FLUSH;
         default:    state_in = S_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready     = 1'b0;
      emit_valid    = 1'b0;
      emit_item     = '{node: '0, status: STAT_VISITED, last: 1'b0};
      adj_port      = '0;
      work_port     = '0;
      deg_we        = 1'b0;
      deg_clr       = 1'b0;
      deg_wr_idx    = a_ff;
      deg_wr_val    = deg_rd + DEG_W'(1);
      mode_dfs_in   = mode_dfs_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      cur_in        = cur_ff;
      deg_a_in      = deg_a_ff;
      status_in     = status_ff;
      visited_in    = visited_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      nb_pend_in    = nb_pend_ff;
      nvis_in       = nvis_ff;
      pend_valid_in = pend_valid_ff;
      pend_node_in  = pend_node_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               a_in        = node_a;
               b_in        = node_b;
               cur_in      = start_node;
               mode_dfs_in = (req_kind == REQ_DFS);
               if (req_kind == REQ_CLEAR) begin
                  deg_clr   = 1'b1;
                  status_in = STAT_CLEARED;
               end
            end
         end
         S_ADD_A: begin
            deg_a_in = deg_rd;
         end
         S_ADD_B: begin
            if (add_ok) begin
               adj_port.wr_en   = 1'b1;
               adj_port.wr_addr = adj_addr(a_ff, deg_a_ff);
               adj_port.wr_data = b_ff;
               deg_we           = 1'b1;
               deg_wr_idx       = a_ff;
               deg_wr_val       = deg_a_ff + DEG_W'(1);
               status_in        = STAT_STORED;
            end else begin
               status_in = STAT_REJECTED;
            end
         end
         S_ADD_W2: begin
            adj_port.wr_en   = 1'b1;
            adj_port.wr_addr = adj_addr(b_ff, deg_rd);
            adj_port.wr_data = a_ff;
            deg_we           = 1'b1;
            deg_wr_idx       = b_ff;
            deg_wr_val       = deg_rd + DEG_W'(1);
         end
         S_RESULT: begin
            emit_valid = 1'b1;
            emit_item  = '{node: '0, status: status_ff, last: 1'b1};
         end
         S_INIT: begin
            visited_in = '0;
            if (!mode_dfs_ff) begin
               visited_in[cur_ff] = 1'b1;
            end
            work_port.wr_en   = 1'b1;
            work_port.wr_addr = '0;
            work_port.wr_data = cur_ff;
            count_in          = CNT_W'(1);
            head_in           = '0;
            nvis_in           = '0;
            pend_valid_in     = 1'b0;
         end
         S_POP: begin
            if (pop_ok) begin
               work_port.rd_en = 1'b1;
               if (mode_dfs_ff) begin
                  work_port.rd_addr = cnt_dec[WORK_AW-1:0];
                  count_in          = cnt_dec;
               end else begin
                  work_port.rd_addr = head_ff[WORK_AW-1:0];
                  head_in           = head_ff + CNT_W'(1);
               end
            end
         end
         S_POP_WAIT: begin
            cur_in     = work_rd_data;
            idx_in     = '0;
            nb_pend_in = 1'b0;
            if (mode_dfs_ff && !vis_rd) begin
               visited_in[work_rd_data] = 1'b1;
            end
         end
         S_VISIT: begin
            emit_valid = pend_valid_ff;
            emit_item  = '{node: pend_node_ff, status: STAT_VISITED, last: 1'b0};
            if (out_free) begin
               pend_node_in  = cur_ff;
               pend_valid_in = 1'b1;
               nvis_in       = nvis_ff + NVIS_W'(1);
            end
         end
         S_SCAN: begin
            if (nb_pend_ff && !vis_rd) begin
               if (!mode_dfs_ff) begin
                  visited_in[adj_rd_data] = 1'b1;
               end
               if (count_ff < CNT_W'(WORK_DEPTH)) begin
                  work_port.wr_en   = 1'b1;
                  work_port.wr_addr = count_ff[WORK_AW-1:0];
                  work_port.wr_data = adj_rd_data;
                  count_in          = count_ff + CNT_W'(1);
               end
            end
            if (scan_more) begin
               adj_port.rd_en   = 1'b1;
               adj_port.rd_addr = adj_addr(cur_ff, idx_ff);
               idx_in           = idx_ff + DEG_W'(1);
               nb_pend_in       = 1'b1;
            end else begin
               nb_pend_in = 1'b0;
            end
         end
         S_FLUSH: begin
            emit_valid = pend_valid_ff;
            emit_item  = '{node: pend_node_ff, status: STAT_VISITED, last: 1'b1};
            if (out_free) begin
               pend_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         visited_ff    <= '0;
         count_ff      <= '0;
         nvis_ff       <= '0;
         pend_valid_ff <= 1'b0;
         nb_pend_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         visited_ff    <= visited_in;
         count_ff      <= count_in;
         nvis_ff       <= nvis_in;
         pend_valid_ff <= pend_valid_in;
         nb_pend_ff    <= nb_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || deg_clr) begin
         for (int i = 0; i < NODES; i++) begin
            deg_ff[i] <= '0;
         end
      end else if (deg_we) begin
         deg_ff[deg_wr_idx] <= deg_wr_val;
      end
   end

   always_ff @(posedge clock) begin
      mode_dfs_ff  <= mode_dfs_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      cur_ff       <= cur_in;
      deg_a_ff     <= deg_a_in;
      status_ff    <= status_in;
      head_ff      <= head_in;
      idx_ff       <= idx_in;
      pend_node_ff <= pend_node_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(WORK_DEPTH))
      else $error("work store fill level out of range");

   a_nvis_bound: assert property (@(posedge clock) disable iff (reset)
      nvis_ff <= NVIS_W'(MAX_RESULTS))
      else $error("visit count out of range");

   a_pop_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP_WAIT) |-> ($past(state_ff) == S_POP))
      else $error("work store data used without a read");

   a_bfs_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP && $past(state_ff) == S_INIT && !mode_dfs_ff)
      |-> $onehot(visited_ff))
      else $error("breadth-first walk did not mark only its start");

   a_last_src: assert property (@(posedge clock) disable iff (reset)
      (emit_valid && emit_item.last) |-> (state_ff == S_RESULT || state_ff == S_FLUSH))
      else $error("final flag outside a closing state");

endmodule

// ===== sv/graph_bfs_dfs_traversal_unit.sv =====
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal_unit
// undirected graph store with breadth-first and depth-first walks
// ----------------------------------------------------------------------------
// requests come in on the req_ stream: tuser holds the request kind (add edge,
// breadth-first walk, depth-first walk, clear), tdata the edge endpoints
// and the walk start. one request is taken at a time; req_tready is high only
// while the sequencer is idle.
// results leave on the rsp_ stream: tdata holds the node, tuser the status,
// tlast marks the final result of a request. a walk's cost grows with each
// visited node and each adjacency entry scanned, and a depth-first walk also
// pays for each discarded stack entry.
// adjacency lists and the walk queue/stack live in two single-read rams.
// reset empties all lists and the visited bits at once; no clearing pass.
// a stalled receiver holds the output register; the walk then pauses at the
// next visit until the waiting transfer is taken.
// ----------------------------------------------------------------------------
module graph_bfs_dfs_traversal_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gbt_pkg::REQ_TDATA_W-1:0]     req_tdata,  // node_a, node_b, start_node, pad
   input  logic [1:0]                          req_tuser,  // req_type
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gbt_pkg::RSP_TDATA_W-1:0]     rsp_tdata,  // node, pad
   output logic [1:0]                          rsp_tuser,  // status
   output logic                                rsp_tlast
);

   import gbt_pkg::*;

   logic              emit_valid;
   logic              emit_ready;
   rsp_item_type      emit_item;
   adj_port_type      adj_port;
   work_port_type     work_port;
   logic [NODE_W-1:0] adj_rd_data;
   logic [NODE_W-1:0] work_rd_data;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;

   gbt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_kind     (req_kind_type'(req_tuser)),
      .node_a       (req_tdata[NODE_W-1:0]),
      .node_b       (req_tdata[2*NODE_W-1:NODE_W]),
      .start_node   (req_tdata[3*NODE_W-1:2*NODE_W]),
      .emit_valid   (emit_valid),
      .emit_ready   (emit_ready),
      .emit_item    (emit_item),
      .adj_port     (adj_port),
      .adj_rd_data  (adj_rd_data),
      .work_port    (work_port),
      .work_rd_data (work_rd_data)
   );

   gbt_ram #(.WIDTH(NODE_W), .DEPTH(SLOTS)) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_port.wr_en),
      .wr_addr (adj_port.wr_addr),
      .wr_data (adj_port.wr_data),
      .rd_en   (adj_port.rd_en),
      .rd_addr (adj_port.rd_addr),
      .rd_data (adj_rd_data)
   );

   gbt_ram #(.WIDTH(NODE_W), .DEPTH(WORK_DEPTH)) u_work_ram (
      .clock   (clock),
      .wr_en   (work_port.wr_en),
      .wr_addr (work_port.wr_addr),
      .wr_data (work_port.wr_data),
      .rd_en   (work_port.rd_en),
      .rd_addr (work_port.rd_addr),
      .rd_data (work_rd_data)
   );

   // output register
   assign emit_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (emit_ready) begin
         rsp_valid_in = emit_valid;
         rsp_item_in  = emit_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_item_ff.node);
   assign rsp_tuser  = rsp_item_ff.status;
   assign rsp_tlast  = rsp_item_ff.last;

endmodule
